// ----- src/lfh_pkg.sv -----
package lfh_pkg;

   localparam int NodeW   = 32;
   localparam int EpochW  = 64;
   localparam int TimeW   = 64;
   localparam int SeqW    = 64;
   localparam int LeaseW  = 32;
   localparam int CsrW    = 32;
   localparam int CsrIdxW = 3;
   localparam int ModeW   = 3;
   localparam int StatusW = 3;

   // operation codes
   localparam logic [ModeW-1:0] MODE_INIT          = 3'd0;
   localparam logic [ModeW-1:0] MODE_RENEW         = 3'd1;
   localparam logic [ModeW-1:0] MODE_FENCE_REQ     = 3'd2;
   localparam logic [ModeW-1:0] MODE_FENCE_CONFIRM = 3'd3;
   localparam logic [ModeW-1:0] MODE_TAKEOVER      = 3'd4;

   // status codes
   localparam logic [StatusW-1:0] ST_OK       = 3'd0;
   localparam logic [StatusW-1:0] ST_INVALID  = 3'd1;
   localparam logic [StatusW-1:0] ST_DENIED   = 3'd2;
   localparam logic [StatusW-1:0] ST_AGAIN    = 3'd3;
   localparam logic [StatusW-1:0] ST_OVERFLOW = 3'd4;

   // register indexes
   localparam logic [CsrIdxW-1:0] CSR_INIT_ACTIVE  = 3'd0;
   localparam logic [CsrIdxW-1:0] CSR_INIT_STANDBY = 3'd1;
   localparam logic [CsrIdxW-1:0] CSR_LEASE_PERIOD = 3'd2;
   localparam logic [CsrIdxW-1:0] CSR_LEASE_FLOOR  = 3'd3;
   localparam logic [CsrIdxW-1:0] CSR_LEASE_CEIL   = 3'd4;

   typedef struct packed {
      logic [NodeW-1:0]  init_active;
      logic [NodeW-1:0]  init_standby;
      logic [LeaseW-1:0] lease_period;
      logic [LeaseW-1:0] lease_floor;
      logic [LeaseW-1:0] lease_ceiling;
   } csr_type;

   typedef struct packed {
      logic [ModeW-1:0]  mode;
      logic [NodeW-1:0]  node_id;
      logic [EpochW-1:0] claimed_epoch;
      logic [TimeW-1:0]  now_ms;
      logic              fence_ack;
   } req_type;

   typedef struct packed {
      logic              init_done;
      logic [NodeW-1:0]  active_id;
      logic [NodeW-1:0]  standby_id;
      logic [EpochW-1:0] epoch;
      logic [LeaseW-1:0] lease_len;
      logic [TimeW-1:0]  deadline;
      logic              fenced;
      logic [SeqW-1:0]   seq;
   } lease_state_type;

   typedef struct packed {
      logic [StatusW-1:0] status;
      logic               fence_request;
      logic [NodeW-1:0]   fence_target;
   } verdict_type;

   // now + len, clamped at all ones
   function automatic logic [TimeW-1:0] sat_deadline(input logic [TimeW-1:0] now,
                                                     input logic [LeaseW-1:0] len);
      logic [TimeW:0] sum;
      sum = {1'b0, now} + {{(TimeW-LeaseW+1){1'b0}}, len};
      return sum[TimeW] ? {TimeW{1'b1}} : sum[TimeW-1:0];
   endfunction

endpackage

// ----- src/lease_failover_handover.sv -----
// An accepted transaction waits in the request register; its result drives rsp_* from the
// result register. One transaction per cycle unless rsp_stall holds the result register.
// The lease state moves at the same edge that loads the result register; the next one sees it.
// Reset (synchronous, active high): pipeline emptied, lease state all zero
// (not initialised), configuration registers back to 1, 2, 1000, 1, all ones.
module lease_failover_handover (
   input  logic                        clock,
   input  logic                        reset,
   // request channel
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [lfh_pkg::ModeW-1:0]   req_mode,
   input  logic [lfh_pkg::NodeW-1:0]   req_node_id,
   input  logic [lfh_pkg::EpochW-1:0]  req_claimed_epoch,
   input  logic [lfh_pkg::TimeW-1:0]   req_now_ms,
   input  logic                        req_fence_ack,
   // response channel
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [lfh_pkg::StatusW-1:0] rsp_status_code,
   output logic                        rsp_fence_request,
   output logic [lfh_pkg::NodeW-1:0]   rsp_fence_target,
   output logic                        rsp_is_initialized,
   output logic [lfh_pkg::NodeW-1:0]   rsp_current_active,
   output logic [lfh_pkg::NodeW-1:0]   rsp_current_standby,
   output logic [lfh_pkg::EpochW-1:0]  rsp_current_epoch,
   output logic                        rsp_is_fenced,
   output logic [lfh_pkg::TimeW-1:0]   rsp_current_deadline,
   output logic [lfh_pkg::SeqW-1:0]    rsp_current_sequence,
   // configuration writes
   input  logic                        csr_wr_en,
   input  logic [lfh_pkg::CsrIdxW-1:0] csr_index,
   input  logic [lfh_pkg::CsrW-1:0]    csr_wdata
);

   // result register contents: verdict plus a snapshot of the state after the transaction
   typedef struct packed {
      lfh_pkg::verdict_type     verdict;
      lfh_pkg::lease_state_type snap;
   } rsp_type;

   lfh_pkg::csr_type         cfg;
   lfh_pkg::req_type         req_in;
   lfh_pkg::req_type         req_ff;
   logic                     req_valid_ff;
   lfh_pkg::lease_state_type state_ff;
   lfh_pkg::lease_state_type state_in;
   lfh_pkg::verdict_type     verdict;
   rsp_type                  rsp_ff;
   rsp_type                  rsp_in;
   logic                     rsp_valid_ff;

   logic rsp_advance;   // result register may take a new transaction
   logic req_load;      // request register takes a new transaction
   logic commit;        // held transaction is resolved this cycle

   lfh_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // --- flow control -------------------------------------------------------
   // Output register is free when empty or being drained; the request
   // register only holds when its transaction cannot move on.
   assign rsp_advance = !rsp_valid_ff || !rsp_stall;
   assign req_stall   = req_valid_ff && !rsp_advance;
   assign req_load    = req_valid && !req_stall;
   assign commit      = req_valid_ff && rsp_advance;

   assign req_in.mode          = req_mode;
   assign req_in.node_id       = req_node_id;
   assign req_in.claimed_epoch = req_claimed_epoch;
   assign req_in.now_ms        = req_now_ms;
   assign req_in.fence_ack     = req_fence_ack;

   // --- decision logic -----------------------------------------------------
   // One pass over the held request against the live lease state.
   lfh_core u_core (
      .req     (req_ff),
      .cfg     (cfg),
      .cur     (state_ff),
      .nxt     (state_in),
      .verdict (verdict)
   );

   assign rsp_in.verdict = verdict;
   assign rsp_in.snap    = state_in;

   // --- control registers --------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         if (!req_stall) begin
            req_valid_ff <= req_valid;
         end
         if (rsp_advance) begin
            rsp_valid_ff <= req_valid_ff;
         end
         // state moves exactly once per resolved transaction
         if (commit) begin
            state_ff <= state_in;
         end
      end
   end

   // --- payload registers --------------------------------------------------
   always_ff @(posedge clock) begin
      if (req_load) begin
         req_ff <= req_in;
      end
      if (commit) begin
         rsp_ff <= rsp_in;
      end
   end

   // --- response ports -----------------------------------------------------
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status_code      = rsp_ff.verdict.status;
   assign rsp_fence_request    = rsp_ff.verdict.fence_request;
   assign rsp_fence_target     = rsp_ff.verdict.fence_target;
   assign rsp_is_initialized   = rsp_ff.snap.init_done;
   assign rsp_current_active   = rsp_ff.snap.active_id;
   assign rsp_current_standby  = rsp_ff.snap.standby_id;
   assign rsp_current_epoch    = rsp_ff.snap.epoch;
   assign rsp_is_fenced        = rsp_ff.snap.fenced;
   assign rsp_current_deadline = rsp_ff.snap.deadline;
   assign rsp_current_sequence = rsp_ff.snap.seq;

endmodule

// ----- src/lfh_csr.sv -----
module lfh_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [lfh_pkg::CsrIdxW-1:0] csr_index,
   input  logic [lfh_pkg::CsrW-1:0]    csr_wdata,
   output lfh_pkg::csr_type            cfg
);

   lfh_pkg::csr_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.init_active   <= 32'd1;
         cfg_ff.init_standby  <= 32'd2;
         cfg_ff.lease_period  <= 32'd1000;
         cfg_ff.lease_floor   <= 32'd1;
         cfg_ff.lease_ceiling <= 32'hFFFF_FFFF;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            lfh_pkg::CSR_INIT_ACTIVE:  cfg_ff.init_active   <= csr_wdata;
            lfh_pkg::CSR_INIT_STANDBY: cfg_ff.init_standby  <= csr_wdata;
            lfh_pkg::CSR_LEASE_PERIOD: cfg_ff.lease_period  <= csr_wdata;
            lfh_pkg::CSR_LEASE_FLOOR:  cfg_ff.lease_floor   <= csr_wdata;
            lfh_pkg::CSR_LEASE_CEIL:   cfg_ff.lease_ceiling <= csr_wdata;
            default: ;   // unmapped index, dropped
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- src/lfh_core.sv -----
module lfh_core (
   input  lfh_pkg::req_type         req,
   input  lfh_pkg::csr_type         cfg,
   input  lfh_pkg::lease_state_type cur,
   output lfh_pkg::lease_state_type nxt,
   output lfh_pkg::verdict_type     verdict
);

   logic expired;
   logic epoch_zero;
   logic epoch_match;
   logic node_zero;
   logic seq_max;
   logic epoch_max;
   logic cfg_ok;
   logic [lfh_pkg::TimeW-1:0] renew_deadline;

   assign expired     = req.now_ms >= cur.deadline;
   assign epoch_zero  = req.claimed_epoch == '0;
   assign epoch_match = req.claimed_epoch == cur.epoch;
   assign node_zero   = req.node_id == '0;
   assign seq_max     = &cur.seq;
   assign epoch_max   = &cur.epoch;
   assign cfg_ok      = (cfg.init_active != '0) && (cfg.init_standby != '0) &&
                        (cfg.init_active != cfg.init_standby) &&
                        (cfg.lease_period >= cfg.lease_floor) &&
                        (cfg.lease_period <= cfg.lease_ceiling);
   assign renew_deadline = lfh_pkg::sat_deadline(req.now_ms, cur.lease_len);

   always_comb begin
      nxt                   = cur;
      verdict.status        = lfh_pkg::ST_INVALID;
      verdict.fence_request = 1'b0;
      verdict.fence_target  = '0;
      unique case (req.mode)
         lfh_pkg::MODE_INIT: begin
            if (!cur.init_done && cfg_ok) begin
               nxt.init_done  = 1'b1;
               nxt.active_id  = cfg.init_active;
               nxt.standby_id = cfg.init_standby;
               nxt.lease_len  = cfg.lease_period;
               nxt.epoch      = {{(lfh_pkg::EpochW-1){1'b0}}, 1'b1};
               nxt.seq        = {{(lfh_pkg::SeqW-1){1'b0}}, 1'b1};
               nxt.deadline   = lfh_pkg::sat_deadline(req.now_ms, cfg.lease_period);
               nxt.fenced     = 1'b0;
               verdict.status = lfh_pkg::ST_OK;
            end
         end
         lfh_pkg::MODE_RENEW: begin
            if (!cur.init_done || node_zero || epoch_zero) begin
               verdict.status = lfh_pkg::ST_INVALID;
            end else if (req.node_id != cur.active_id || !epoch_match) begin
               verdict.status = lfh_pkg::ST_DENIED;
            end else if (expired) begin
               verdict.status = lfh_pkg::ST_AGAIN;
            end else if (seq_max) begin
               verdict.status = lfh_pkg::ST_OVERFLOW;
            end else begin
               nxt.deadline   = renew_deadline;
               nxt.seq        = cur.seq + 1'b1;
               verdict.status = lfh_pkg::ST_OK;
            end
         end
         lfh_pkg::MODE_FENCE_REQ: begin
            if (!cur.init_done || epoch_zero) begin
               verdict.status = lfh_pkg::ST_INVALID;
            end else if (!epoch_match) begin
               verdict.status = lfh_pkg::ST_DENIED;
            end else if (!expired) begin
               verdict.status = lfh_pkg::ST_AGAIN;
            end else begin
               // strobe goes out whether or not the agent takes it
               verdict.fence_request = 1'b1;
               verdict.fence_target  = cur.active_id;
               verdict.status = req.fence_ack ? lfh_pkg::ST_OK : lfh_pkg::ST_AGAIN;
            end
         end
         lfh_pkg::MODE_FENCE_CONFIRM: begin
            if (!cur.init_done || epoch_zero) begin
               verdict.status = lfh_pkg::ST_INVALID;
            end else if (!epoch_match) begin
               verdict.status = lfh_pkg::ST_DENIED;
            end else if (!expired || !req.fence_ack) begin
               verdict.status = lfh_pkg::ST_AGAIN;
            end else if (cur.fenced) begin
               verdict.status = lfh_pkg::ST_OK;
            end else if (seq_max) begin
               verdict.status = lfh_pkg::ST_OVERFLOW;
            end else begin
               nxt.fenced     = 1'b1;
               nxt.seq        = cur.seq + 1'b1;
               verdict.status = lfh_pkg::ST_OK;
            end
         end
         lfh_pkg::MODE_TAKEOVER: begin
            if (!cur.init_done || node_zero || epoch_zero) begin
               verdict.status = lfh_pkg::ST_INVALID;
            end else if (req.node_id != cur.standby_id || !epoch_match) begin
               verdict.status = lfh_pkg::ST_DENIED;
            end else if (!expired || !cur.fenced) begin
               verdict.status = lfh_pkg::ST_AGAIN;
            end else if (epoch_max || seq_max) begin
               verdict.status = lfh_pkg::ST_OVERFLOW;
            end else begin
               nxt.active_id  = cur.standby_id;
               nxt.standby_id = cur.active_id;
               nxt.epoch      = cur.epoch + 1'b1;
               nxt.seq        = cur.seq + 1'b1;
               nxt.fenced     = 1'b0;
               nxt.deadline   = renew_deadline;
               verdict.status = lfh_pkg::ST_OK;
            end
         end
         default: ;   // unused codes: invalid, no change
      endcase
   end

endmodule

// ----- verif/lease_failover_handover_tb.sv -----
module lease_failover_handover_tb;

   localparam int MODE_BITS = lfh_pkg::ModeW;
   localparam int IDX_BITS  = lfh_pkg::CsrIdxW;

   // mode values the block does not decode
   localparam logic [lfh_pkg::ModeW-1:0] MODE_SPARE_FIRST = 3'd5;
   localparam logic [lfh_pkg::ModeW-1:0] MODE_SPARE_LAST  = 3'd7;

   localparam logic [lfh_pkg::TimeW-1:0] TIME_MAX = '1;
   localparam int HOLD_CYCLES  = 60;   // long receiver hold-off
   localparam int DRAIN_CYCLES = 8;    // a little margin after the last response
   localparam int RANDOM_ITEMS = 1950;
   localparam int SEGMENTS     = 4;

   // one response, field for field as it leaves the block
   typedef struct packed {
      logic [lfh_pkg::StatusW-1:0] status;
      logic                        fence_req;
      logic [lfh_pkg::NodeW-1:0]   fence_tgt;
      logic                        initialised;
      logic [lfh_pkg::NodeW-1:0]   active;
      logic [lfh_pkg::NodeW-1:0]   standby;
      logic [lfh_pkg::EpochW-1:0]  epoch;
      logic                        fenced;
      logic [lfh_pkg::TimeW-1:0]   deadline;
      logic [lfh_pkg::SeqW-1:0]    seq_count;
   } lease_view_type;

   // now + len, pinned at all ones
   function automatic logic [lfh_pkg::TimeW-1:0] clamp_add(logic [lfh_pkg::TimeW-1:0] t,
                                                           logic [lfh_pkg::TimeW-1:0] d);
      return (TIME_MAX - t < d) ? TIME_MAX : t + d;
   endfunction

   // ------------------------------------------------------------------
   // Lease tracker: own copy of the registers and the lease state.
   // Every accepted request transaction is folded in and its expected
   // response queued; responses are matched in order.
   // ------------------------------------------------------------------
   class lease_tracker;
      // register reset values, in index order
      bit [lfh_pkg::CsrW-1:0]   regs [5] = '{32'd1, 32'd2, 32'd1000, 32'd1, 32'hFFFF_FFFF};
      bit                       initialised;
      bit [lfh_pkg::NodeW-1:0]  active;
      bit [lfh_pkg::NodeW-1:0]  standby;
      bit [lfh_pkg::EpochW-1:0] epoch;
      bit [lfh_pkg::LeaseW-1:0] lease;
      bit [lfh_pkg::TimeW-1:0]  deadline;
      bit                       fenced;
      bit [lfh_pkg::SeqW-1:0]   seq_count;
      lease_view_type           pending [$];
      int                       failures;
      int                       checked;
      int                       handovers;
      int                       strobes;
      int                       status_hits [8];

      function void write_reg(logic [lfh_pkg::CsrIdxW-1:0] idx, logic [lfh_pkg::CsrW-1:0] val);
         if (idx <= lfh_pkg::CSR_LEASE_CEIL)
            regs[idx] = val;
      endfunction

      function void absorb_request(lfh_pkg::req_type r);
         lease_view_type              v;
         bit [lfh_pkg::StatusW-1:0]   st;
         bit                          in_lease;
         bit [lfh_pkg::NodeW-1:0]     prev;
         st          = lfh_pkg::ST_INVALID;
         v.fence_req = 1'b0;
         v.fence_tgt = '0;
         in_lease    = r.now_ms < deadline;
         case (r.mode)
            lfh_pkg::MODE_INIT: begin
               if (!initialised && regs[lfh_pkg::CSR_INIT_ACTIVE] != 0
                   && regs[lfh_pkg::CSR_INIT_STANDBY] != 0
                   && regs[lfh_pkg::CSR_INIT_ACTIVE] != regs[lfh_pkg::CSR_INIT_STANDBY]
                   && regs[lfh_pkg::CSR_LEASE_PERIOD] >= regs[lfh_pkg::CSR_LEASE_FLOOR]
                   && regs[lfh_pkg::CSR_LEASE_PERIOD] <= regs[lfh_pkg::CSR_LEASE_CEIL]) begin
                  active      = regs[lfh_pkg::CSR_INIT_ACTIVE];
                  standby     = regs[lfh_pkg::CSR_INIT_STANDBY];
                  lease       = regs[lfh_pkg::CSR_LEASE_PERIOD];
                  epoch       = 64'd1;
                  deadline    = clamp_add(r.now_ms, {32'b0, lease});
                  fenced      = 1'b0;
                  seq_count   = 64'd1;
                  initialised = 1'b1;
                  st          = lfh_pkg::ST_OK;
               end
            end
            lfh_pkg::MODE_RENEW: begin
               if (!initialised || r.node_id == 0 || r.claimed_epoch == 0)
                  st = lfh_pkg::ST_INVALID;
               else if (r.node_id != active || r.claimed_epoch != epoch)
                  st = lfh_pkg::ST_DENIED;
               else if (!in_lease) st = lfh_pkg::ST_AGAIN;
               else if (&seq_count) st = lfh_pkg::ST_OVERFLOW;
               else begin
                  deadline = clamp_add(r.now_ms, {32'b0, lease});
                  seq_count++;
                  st = lfh_pkg::ST_OK;
               end
            end
            lfh_pkg::MODE_FENCE_REQ: begin
               if (!initialised || r.claimed_epoch == 0) st = lfh_pkg::ST_INVALID;
               else if (r.claimed_epoch != epoch) st = lfh_pkg::ST_DENIED;
               else if (in_lease) st = lfh_pkg::ST_AGAIN;
               else begin
                  // strobe goes out whatever the agent answers
                  v.fence_req = 1'b1;
                  v.fence_tgt = active;
                  strobes++;
                  st = r.fence_ack ? lfh_pkg::ST_OK : lfh_pkg::ST_AGAIN;
               end
            end
            lfh_pkg::MODE_FENCE_CONFIRM: begin
               if (!initialised || r.claimed_epoch == 0) st = lfh_pkg::ST_INVALID;
               else if (r.claimed_epoch != epoch) st = lfh_pkg::ST_DENIED;
               else if (in_lease || !r.fence_ack) st = lfh_pkg::ST_AGAIN;
               else if (fenced) st = lfh_pkg::ST_OK;
               else if (&seq_count) st = lfh_pkg::ST_OVERFLOW;
               else begin
                  fenced = 1'b1;
                  seq_count++;
                  st = lfh_pkg::ST_OK;
               end
            end
            lfh_pkg::MODE_TAKEOVER: begin
               if (!initialised || r.node_id == 0 || r.claimed_epoch == 0)
                  st = lfh_pkg::ST_INVALID;
               else if (r.node_id != standby || r.claimed_epoch != epoch)
                  st = lfh_pkg::ST_DENIED;
               else if (in_lease || !fenced) st = lfh_pkg::ST_AGAIN;
               else if (&epoch || &seq_count) st = lfh_pkg::ST_OVERFLOW;
               else begin
                  prev     = active;
                  active   = standby;
                  standby  = prev;
                  epoch++;
                  seq_count++;
                  fenced   = 1'b0;
                  deadline = clamp_add(r.now_ms, {32'b0, lease});
                  handovers++;
                  st = lfh_pkg::ST_OK;
               end
            end
            default: st = lfh_pkg::ST_INVALID;
         endcase
         v.status      = st;
         v.initialised = initialised;
         v.active      = active;
         v.standby     = standby;
         v.epoch       = epoch;
         v.fenced      = fenced;
         v.deadline    = deadline;
         v.seq_count   = seq_count;
         pending.push_back(v);
      endfunction

      task report(string what);
         failures++;
         $display("mismatch at %0t: %s", $time, what);
      endtask

      task compare_field(string name, logic [63:0] got, logic [63:0] want);
         if (got !== want)
            report($sformatf("transaction %0d %s: got %0h, want %0h",
                             checked, name, got, want));
      endtask

      task match_response(lease_view_type got);
         lease_view_type want;
         if (pending.size() == 0) begin
            report("response with no request outstanding");
            return;
         end
         want = pending.pop_front();
         checked++;
         status_hits[want.status]++;
         compare_field("status_code",      64'(got.status),      64'(want.status));
         compare_field("fence_request",    64'(got.fence_req),   64'(want.fence_req));
         compare_field("fence_target",     64'(got.fence_tgt),   64'(want.fence_tgt));
         compare_field("is_initialized",   64'(got.initialised), 64'(want.initialised));
         compare_field("current_active",   64'(got.active),      64'(want.active));
         compare_field("current_standby",  64'(got.standby),     64'(want.standby));
         compare_field("current_epoch",    got.epoch,            want.epoch);
         compare_field("is_fenced",        64'(got.fenced),      64'(want.fenced));
         compare_field("current_deadline", got.deadline,         want.deadline);
         compare_field("current_sequence", got.seq_count,        want.seq_count);
      endtask
   endclass

   // ------------------------------------------------------------------
   // DUT hookup; every input has a known value from time zero
   // ------------------------------------------------------------------
   logic                          clock;
   logic                          reset                = 1'b1;
   logic                          req_valid            = 1'b0;
   logic                          req_stall;
   logic [lfh_pkg::ModeW-1:0]     req_mode             = '0;
   logic [lfh_pkg::NodeW-1:0]     req_node_id          = '0;
   logic [lfh_pkg::EpochW-1:0]    req_claimed_epoch    = '0;
   logic [lfh_pkg::TimeW-1:0]     req_now_ms           = '0;
   logic                          req_fence_ack        = 1'b0;
   logic                          rsp_valid;
   logic                          rsp_stall            = 1'b0;
   logic [lfh_pkg::StatusW-1:0]   rsp_status_code;
   logic                          rsp_fence_request;
   logic [lfh_pkg::NodeW-1:0]     rsp_fence_target;
   logic                          rsp_is_initialized;
   logic [lfh_pkg::NodeW-1:0]     rsp_current_active;
   logic [lfh_pkg::NodeW-1:0]     rsp_current_standby;
   logic [lfh_pkg::EpochW-1:0]    rsp_current_epoch;
   logic                          rsp_is_fenced;
   logic [lfh_pkg::TimeW-1:0]     rsp_current_deadline;
   logic [lfh_pkg::SeqW-1:0]      rsp_current_sequence;
   logic                          csr_wr_en            = 1'b0;
   logic [lfh_pkg::CsrIdxW-1:0]   csr_index            = '0;
   logic [lfh_pkg::CsrW-1:0]      csr_wdata            = '0;

   lease_tracker tracker = new;

   bit sender_gaps   = 1'b1;   // random idle bursts on the request side
   bit receiver_gaps = 1'b1;   // random stall bursts on the response side
   bit hold_now      = 1'b0;   // ask the receiver for one long hold-off
   int sent;
   int input_stall_cycles;

   lease_failover_handover dut (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // watchdog: far beyond the slowest legal run
   initial begin
      #1_600_000;
      $display("run stalled with %0d responses outstanding", tracker.pending.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // ------------------------------------------------------------------
   // Response side. Values read at the edge are the pre-edge ones, since
   // both the DUT and the drivers update through nonblocking assignments.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         tracker.match_response(lease_view_type'{rsp_status_code, rsp_fence_request,
            rsp_fence_target, rsp_is_initialized, rsp_current_active, rsp_current_standby,
            rsp_current_epoch, rsp_is_fenced, rsp_current_deadline, rsp_current_sequence});
      if (!reset && req_valid && req_stall)
         input_stall_cycles++;
   end

   // Receiver: short random stall bursts, plus one long hold-off on request.
   // rsp_stall gets at most one update per edge.
   initial begin : receiver_side
      int span;
      forever begin
         @(posedge clock);
         if (hold_now) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
            hold_now = 1'b0;
         end else if (receiver_gaps && $urandom_range(0, 5) == 0) begin
            span = $urandom_range(1, 5);
            rsp_stall <= 1'b1;
            repeat (span) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------
   function automatic lfh_pkg::req_type make_req(logic [lfh_pkg::ModeW-1:0] mode,
                                                 logic [lfh_pkg::NodeW-1:0] node,
                                                 logic [lfh_pkg::EpochW-1:0] ep,
                                                 logic [lfh_pkg::TimeW-1:0] now,
                                                 logic ack);
      return lfh_pkg::req_type'{mode, node, ep, now, ack};
   endfunction

   // Hold the transaction until it is taken, then fold it into the tracker
   // so the next one is built from up-to-date lease state.
   task automatic offer(input lfh_pkg::req_type r);
      req_valid         <= 1'b1;
      req_mode          <= r.mode;
      req_node_id       <= r.node_id;
      req_claimed_epoch <= r.claimed_epoch;
      req_now_ms        <= r.now_ms;
      req_fence_ack     <= r.fence_ack;
      do @(posedge clock); while (req_stall);
      tracker.absorb_request(r);
      sent++;
   endtask

   task automatic send(input lfh_pkg::req_type r);
      if (sender_gaps && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      offer(r);
   endtask

   // quiet the request side and let every response come back
   task automatic settle();
      req_valid <= 1'b0;
      while (tracker.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // all five registers back to back; write enable drops once at the end
   task automatic program_regs(input logic [lfh_pkg::CsrW-1:0] act, sby, period, low_len,
                               high_len);
      logic [lfh_pkg::CsrW-1:0] vals [5];
      vals = '{act, sby, period, low_len, high_len};
      for (int i = lfh_pkg::CSR_INIT_ACTIVE; i <= lfh_pkg::CSR_LEASE_CEIL; i++) begin
         csr_wr_en <= 1'b1;
         csr_index <= IDX_BITS'(i);
         csr_wdata <= vals[i];
         @(posedge clock);
         tracker.write_reg(IDX_BITS'(i), vals[i]);
      end
      csr_wr_en <= 1'b0;
   endtask

   task automatic try_init(input logic [lfh_pkg::CsrW-1:0] act, sby, period, low_len, high_len,
                           input logic [lfh_pkg::TimeW-1:0] now);
      program_regs(act, sby, period, low_len, high_len);
      send(make_req(lfh_pkg::MODE_INIT, $urandom, {$urandom, $urandom}, now,
                    $urandom_range(0, 1) != 0));
      settle();
   endtask

   // occasional damage to an otherwise well-formed transaction
   function automatic lfh_pkg::req_type mangle(lfh_pkg::req_type r, bit allow);
      if (allow) begin
         case ($urandom_range(0, 19))
            0: r.node_id = '0;
            1: r.node_id ^= 32'd1 << $urandom_range(0, 31);
            2: r.claimed_epoch = '0;
            3: r.claimed_epoch += 64'd1;
            4: r.fence_ack = !r.fence_ack;
            5: r.claimed_epoch = {$urandom, $urandom};
            default: ;
         endcase
      end
      return r;
   endfunction

   // fence request, confirmation and handover, all at one instant at or past the
   // deadline; a far jump pins the deadline at all ones
   task automatic run_failover(input bit far);
      logic [lfh_pkg::TimeW-1:0] t;
      t = clamp_add(tracker.deadline,
                    far ? TIME_MAX - 64'($urandom_range(0, 2000)) : 64'($urandom_range(0, 500)));
      send(mangle(make_req(lfh_pkg::MODE_FENCE_REQ, $urandom, tracker.epoch, t,
                           $urandom_range(0, 4) != 0), !far));
      send(mangle(make_req(lfh_pkg::MODE_FENCE_CONFIRM, $urandom, tracker.epoch, t,
                           far || $urandom_range(0, 7) != 0), !far));
      send(mangle(make_req(lfh_pkg::MODE_TAKEOVER, tracker.standby, tracker.epoch, t,
                           $urandom_range(0, 1) != 0), !far));
   endtask

   task automatic random_burst();
      int unsigned               pick;
      logic [lfh_pkg::TimeW-1:0] t;
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         // renewal by the active node, now and then too late
         if ($urandom_range(0, 4) == 0)
            t = clamp_add(tracker.deadline, 64'($urandom_range(0, 300)));
         else
            t = tracker.deadline - 64'($urandom_range(1, 1000));
         send(mangle(make_req(lfh_pkg::MODE_RENEW, tracker.active, tracker.epoch, t,
                              $urandom_range(0, 1) != 0), 1'b1));
      end else if (pick < 65) begin
         run_failover(1'b0);
      end else if (pick < 85) begin
         // any defined command by either node, right around the deadline
         t = $urandom_range(0, 1) ? clamp_add(tracker.deadline, 64'($urandom_range(0, 3)))
                                  : tracker.deadline - 64'($urandom_range(1, 3));
         send(mangle(make_req(MODE_BITS'($urandom_range(lfh_pkg::MODE_INIT,
                                                        lfh_pkg::MODE_TAKEOVER)),
                              $urandom_range(0, 1) ? tracker.active : tracker.standby,
                              tracker.epoch, t, $urandom_range(0, 1) != 0), 1'b1));
      end else begin
         // noise: every field random, spare modes included
         send(make_req(MODE_BITS'($urandom_range(lfh_pkg::MODE_INIT, MODE_SPARE_LAST)),
                       $urandom, {$urandom, $urandom}, {$urandom, $urandom},
                       $urandom_range(0, 1) != 0));
      end
   endtask

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin : stimulus
      int target;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // not yet initialised: everything bounces as invalid
      send(make_req(lfh_pkg::MODE_RENEW, 32'd1, 64'd1, '0, 1'b1));
      send(make_req(lfh_pkg::MODE_FENCE_REQ, 32'd1, 64'd1, TIME_MAX, 1'b1));
      send(make_req(lfh_pkg::MODE_TAKEOVER, '1, '1, TIME_MAX, 1'b1));
      for (int m = MODE_SPARE_FIRST; m <= MODE_SPARE_LAST; m++)
         send(make_req(MODE_BITS'(m), 32'd1, 64'd1, 64'd5000, 1'b1));
      settle();

      // broken register settings, each refused at init
      try_init(32'd0, 32'd2, 32'd1000, 32'd1, '1, 64'd7);
      try_init(32'd5, 32'd0, 32'd1000, 32'd1, '1, 64'd7);
      try_init('1, '1, 32'd1000, 32'd1, '1, 64'd7);
      try_init('1, 32'd1, 32'd0, 32'd1, '1, 64'd7);
      try_init('1, 32'd1, '1, 32'd0, 32'hFFFF_FFFE, 64'd7);
      // period sits on both floor and ceiling: accepted, deadline 1000
      try_init('1, 32'd1, 32'd1000, 32'd1000, 32'd1000, 64'd0);

      // directed walk through every command after init
      send(make_req(lfh_pkg::MODE_INIT, 32'd3, 64'd1, 64'd10, 1'b1));
      send(make_req(lfh_pkg::MODE_RENEW, 32'd0, 64'd1, 64'd10, 1'b0));
      send(make_req(lfh_pkg::MODE_RENEW, '1, 64'd0, 64'd10, 1'b0));
      send(make_req(lfh_pkg::MODE_RENEW, 32'd1, 64'd1, 64'd10, 1'b0));
      send(make_req(lfh_pkg::MODE_RENEW, '1, '1, 64'd10, 1'b0));
      send(make_req(lfh_pkg::MODE_RENEW, '1, 64'd1, 64'd999, 1'b0));
      send(make_req(lfh_pkg::MODE_RENEW, '1, 64'd1, 64'd1999, 1'b0));
      send(make_req(lfh_pkg::MODE_FENCE_REQ, 32'd0, 64'd1, 64'd1998, 1'b1));
      send(make_req(lfh_pkg::MODE_FENCE_REQ, 32'd0, 64'd1, 64'd1999, 1'b0));
      send(make_req(lfh_pkg::MODE_FENCE_REQ, 32'd0, 64'd1, 64'd1999, 1'b1));
      send(make_req(lfh_pkg::MODE_FENCE_CONFIRM, 32'd0, 64'd1, 64'd1999, 1'b0));
      send(make_req(lfh_pkg::MODE_TAKEOVER, 32'd1, 64'd1, 64'd1999, 1'b1));
      send(make_req(lfh_pkg::MODE_FENCE_CONFIRM, 32'd0, 64'd1, 64'd1999, 1'b1));
      send(make_req(lfh_pkg::MODE_FENCE_CONFIRM, 32'd0, 64'd1, 64'd1999, 1'b1));
      send(make_req(lfh_pkg::MODE_TAKEOVER, '1, 64'd1, 64'd1999, 1'b1));
      send(make_req(lfh_pkg::MODE_TAKEOVER, 32'd1, 64'd1, 64'd1999, 1'b1));
      settle();

      // random segments; registers rewritten between them while idle
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         if (seg == SEGMENTS - 1) begin
            // final stretch runs flat out on both sides
            sender_gaps   = 1'b0;
            receiver_gaps = 1'b0;
            run_failover(1'b1);
         end
         if (seg == 1)
            hold_now = 1'b1;   // sender keeps going, the pipe fills and stalls the input
         target = sent + RANDOM_ITEMS / SEGMENTS;
         while (sent < target)
            random_burst();
         settle();
         case (seg)
            0: program_regs('0, '0, '0, '0, '0);
            1: program_regs('1, '1, '1, '1, '1);
            2: program_regs($urandom, $urandom, $urandom, $urandom, $urandom);
            default: ;
         endcase
      end

      $display("lease handover: %0d transactions checked, %0d handovers, %0d fence strobes",
               tracker.checked, tracker.handovers, tracker.strobes);
      $display("status ok/invalid/denied/again/overflow %0d/%0d/%0d/%0d/%0d, %0d input stalls",
               tracker.status_hits[lfh_pkg::ST_OK], tracker.status_hits[lfh_pkg::ST_INVALID],
               tracker.status_hits[lfh_pkg::ST_DENIED], tracker.status_hits[lfh_pkg::ST_AGAIN],
               tracker.status_hits[lfh_pkg::ST_OVERFLOW], input_stall_cycles);
      if (tracker.failures == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
